>>> rtl/core/scoa_pkg.sv
package scoa_pkg;

  // Region and size-class geometry
  localparam int REGION_LOG2    = 16;
  localparam int MIN_CLASS_LOG2 = 7;
  localparam int NUM_CLASSES    = REGION_LOG2 - MIN_CLASS_LOG2 + 1;
  localparam int REGION_BYTES   = 1 << REGION_LOG2;

  // Field widths
  localparam int SIZE_W = 17;
  localparam int OFF_W  = 16;
  localparam int BUMP_W = REGION_LOG2 + 1;
  localparam int STAT_W = 2;

  // Class index: 0 .. NUM_CLASSES, where NUM_CLASSES marks "too large" or "not found"
  localparam int CLS_W = $clog2(NUM_CLASSES + 1);
  // Bits that address one class stack in the entry memory
  localparam int KW    = $clog2(NUM_CLASSES);

  // Stream packing
  localparam int IN_TDATA_W  = ((SIZE_W + OFF_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((OFF_W + 7) / 8) * 8;

  // Request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_OOM     = 2'd1;
  localparam logic [STAT_W-1:0] ST_DELETED = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BUMP,
    S_FREE_PUSH,
    S_SEARCH,
    S_POP,
    S_SPLIT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic             req_type;
    logic [CLS_W-1:0] cls;
    logic [OFF_W-1:0] free_offset;
  } req_t;

  typedef struct packed {
    logic [OFF_W-1:0]  result_offset;
    logic [STAT_W-1:0] status;
  } res_t;

  // Class index (log2 minus MIN_CLASS_LOG2) of the smallest block that holds size bytes.
  // Returns NUM_CLASSES when the size does not fit the region.
  function automatic logic [CLS_W-1:0] size_class_idx(input logic [SIZE_W-1:0] size);
    logic [CLS_W-1:0] k;
    k = '0;
    for (int i = MIN_CLASS_LOG2; i < SIZE_W; i++) begin
      if (size > (SIZE_W'(1) << i)) begin
        k = CLS_W'(i - MIN_CLASS_LOG2 + 1);
      end
    end
    return k;
  endfunction

endpackage

>>> rtl/core/size_class_offset_allocator_core.sv
// Size-class offset allocator for one 64 KiB region.
// Input channel (in_*): one request per transfer. tuser carries the request kind
// (0 allocate, 1 free); tdata carries the size in bytes and, for a free, the block offset.
// Output channel (out_*): exactly one response per request, in request order:
// tdata holds the allocated offset (zero for frees and errors, but kept when a split hits
// a full stack), tuser the status (0 ok, 1 out of memory, 2 used after delete, 3 free stack full).
// Configuration: cfg_wr_en writes cfg_wr_data into the backend-deleted flag; write it only
// while no request is in flight.
// Timing: requests are served one at a time by a sequencer around a single adder and one
// entry memory. A bump allocate or free goes through the bump step only; a stack pop or
// push adds a search-and-pop or push step; an allocate that splits a larger block walks up
// the classes one per cycle, pops, then pushes one leftover piece per cycle.
// Response is registered; the next request is taken while a response waits.
// Reset: bump pointer, class stack counts and the deleted flag clear; no clearing pass.
// Stall: if out_tready stays low the finished response holds in the output register and
// the sequencer waits with its next result until the register drains.
module size_class_offset_allocator_core #(
  parameter int FREE_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Request channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [scoa_pkg::IN_TDATA_W-1:0]     in_tdata,   // [16:0] size_bytes, [32:17] free_offset
  input  logic                                in_tuser,   // [0] req_type
  // Response channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [scoa_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [15:0] result_offset
  output logic [scoa_pkg::STAT_W-1:0]         out_tuser,  // [1:0] status
  // Configuration
  input  logic                                cfg_wr_en,
  input  logic                                cfg_wr_data
);

  logic                         deleted_r;
  logic                         in_xfer;
  logic [scoa_pkg::SIZE_W-1:0]  in_size;
  scoa_pkg::req_t               req;
  logic                         req_ready;
  logic                         res_valid;
  logic                         res_ready;
  scoa_pkg::res_t               res;
  logic                         out_valid_r;
  scoa_pkg::res_t               out_res_r;

  // Backend-deleted flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deleted_r <= 1'b0;
    end else if (cfg_wr_en) begin
      deleted_r <= cfg_wr_data;
    end
  end

  // Unpack the request and classify its size up front
  assign in_size         = in_tdata[scoa_pkg::SIZE_W-1:0];
  assign req.req_type    = in_tuser;
  assign req.cls         = scoa_pkg::size_class_idx(in_size);
  assign req.free_offset = in_tdata[scoa_pkg::SIZE_W +: scoa_pkg::OFF_W];

  assign in_tready = req_ready;
  assign in_xfer   = in_tvalid && in_tready;

  scoa_ctrl #(
    .FREE_DEPTH (FREE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_xfer),
    .req       (req),
    .req_ready (req_ready),
    .deleted   (deleted_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: load when empty or draining this cycle
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = scoa_pkg::OUT_TDATA_W'(out_res_r.result_offset);
  assign out_tuser  = out_res_r.status;

endmodule

>>> rtl/core/scoa_ram.sv
module scoa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 640
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/scoa_ctrl.sv
module scoa_ctrl #(
  parameter int FREE_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             req_valid,
  input  scoa_pkg::req_t   req,
  output logic             req_ready,
  input  logic             deleted,
  output logic             res_valid,
  input  logic             res_ready,
  output scoa_pkg::res_t   res
);

  localparam int IDX_W     = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
  localparam int CNT_W     = $clog2(FREE_DEPTH + 1);
  localparam int ADDR_W    = scoa_pkg::KW + IDX_W;
  localparam int RAM_DEPTH = scoa_pkg::NUM_CLASSES << IDX_W;
  localparam int SUM_W     = scoa_pkg::BUMP_W + 1;

  scoa_pkg::state_t state_r, state_nxt;

  logic                        req_type_r, req_type_nxt;
  logic [scoa_pkg::CLS_W-1:0]  k_r, k_nxt;
  logic [scoa_pkg::CLS_W-1:0]  cls_r, cls_nxt;
  logic [scoa_pkg::OFF_W-1:0]  foff_r, foff_nxt;
  logic [scoa_pkg::BUMP_W-1:0] bump_r, bump_nxt;
  logic [scoa_pkg::BUMP_W-1:0] start_r, start_nxt;
  logic [scoa_pkg::OFF_W-1:0]  offset_r, offset_nxt;
  logic [scoa_pkg::STAT_W-1:0] status_r, status_nxt;
  logic [CNT_W-1:0]            cnt_r [scoa_pkg::NUM_CLASSES];

  // One count update per cycle
  logic             cnt_we;
  logic [CNT_W-1:0] cnt_wval;

  logic                      cls_in_range;
  logic [scoa_pkg::KW-1:0]   cls_idx;
  logic [CNT_W-1:0]          cnt_sel;
  logic                      cnt_full;
  logic [CNT_W-1:0]          cnt_dec;

  // Shared adder
  logic [scoa_pkg::CLS_W-1:0]  piece_cls;
  logic [scoa_pkg::BUMP_W-1:0] piece;
  logic [scoa_pkg::BUMP_W-1:0] opa;
  logic [SUM_W-1:0]            sum;

  // Entry memory ports
  logic                        ram_we;
  logic [ADDR_W-1:0]           ram_waddr;
  logic                        ram_re;
  logic [ADDR_W-1:0]           ram_raddr;
  logic [scoa_pkg::OFF_W-1:0]  ram_rdata;

  scoa_ram #(
    .WIDTH (scoa_pkg::OFF_W),
    .DEPTH (RAM_DEPTH)
  ) u_entries (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (start_r[scoa_pkg::OFF_W-1:0]),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign cls_in_range = (cls_r < scoa_pkg::CLS_W'(scoa_pkg::NUM_CLASSES));
  assign cls_idx      = cls_r[scoa_pkg::KW-1:0];
  assign cnt_sel      = cls_in_range ? cnt_r[cls_idx] : '0;
  assign cnt_full     = (cnt_sel >= CNT_W'(FREE_DEPTH));
  assign cnt_dec      = cnt_sel - CNT_W'(1);

  assign piece_cls = (state_r == scoa_pkg::S_SPLIT) ? cls_r : k_r;
  assign piece     = scoa_pkg::BUMP_W'(1) << (5'(piece_cls) + 5'(scoa_pkg::MIN_CLASS_LOG2));

  always_comb begin
    opa = start_r;
    unique case (state_r)
      scoa_pkg::S_BUMP: begin
        opa = (req_type_r == scoa_pkg::REQ_ALLOC) ? bump_r : scoa_pkg::BUMP_W'(foff_r);
      end
      scoa_pkg::S_POP: begin
        opa = scoa_pkg::BUMP_W'(ram_rdata);
      end
      default: begin
        opa = start_r;
      end
    endcase
  end

  assign sum = SUM_W'(opa) + SUM_W'(piece);

  // Pushes write at the current top, pops read one below it
  assign ram_waddr = {cls_idx, cnt_sel[IDX_W-1:0]};
  assign ram_raddr = {cls_idx, cnt_dec[IDX_W-1:0]};

  assign req_ready = (state_r == scoa_pkg::S_IDLE);
  assign res_valid = (state_r == scoa_pkg::S_RESP);
  assign res.result_offset = offset_r;
  assign res.status        = status_r;

  always_comb begin
    state_nxt    = state_r;
    req_type_nxt = req_type_r;
    k_nxt        = k_r;
    cls_nxt      = cls_r;
    foff_nxt     = foff_r;
    bump_nxt     = bump_r;
    start_nxt    = start_r;
    offset_nxt   = offset_r;
    status_nxt   = status_r;
    cnt_we       = 1'b0;
    cnt_wval     = cnt_sel;
    ram_we       = 1'b0;
    ram_re       = 1'b0;

    unique case (state_r)
      scoa_pkg::S_IDLE: begin
        if (req_valid) begin
          req_type_nxt = req.req_type;
          k_nxt        = req.cls;
          cls_nxt      = req.cls;
          foff_nxt     = req.free_offset;
          start_nxt    = scoa_pkg::BUMP_W'(req.free_offset);
          offset_nxt   = '0;
          if (req.cls == scoa_pkg::CLS_W'(scoa_pkg::NUM_CLASSES)) begin
            status_nxt = scoa_pkg::ST_OOM;
            state_nxt  = scoa_pkg::S_RESP;
          end else begin
            status_nxt = scoa_pkg::ST_OK;
            state_nxt  = scoa_pkg::S_BUMP;
          end
        end
      end

      scoa_pkg::S_BUMP: begin
        if (req_type_r == scoa_pkg::REQ_ALLOC) begin
          if (sum <= SUM_W'(scoa_pkg::REGION_BYTES)) begin
            offset_nxt = bump_r[scoa_pkg::OFF_W-1:0];
            bump_nxt   = sum[scoa_pkg::BUMP_W-1:0];
            state_nxt  = scoa_pkg::S_RESP;
          end else if (deleted) begin
            status_nxt = scoa_pkg::ST_DELETED;
            state_nxt  = scoa_pkg::S_RESP;
          end else begin
            state_nxt = scoa_pkg::S_SEARCH;
          end
        end else begin
          if (SUM_W'(bump_r) == sum) begin
            bump_nxt  = scoa_pkg::BUMP_W'(foff_r);
            state_nxt = scoa_pkg::S_RESP;
          end else if (deleted) begin
            status_nxt = scoa_pkg::ST_DELETED;
            state_nxt  = scoa_pkg::S_RESP;
          end else begin
            state_nxt = scoa_pkg::S_FREE_PUSH;
          end
        end
      end

      scoa_pkg::S_FREE_PUSH: begin
        if (cnt_full) begin
          status_nxt = scoa_pkg::ST_FULL;
        end else begin
          ram_we   = 1'b1;
          cnt_we   = 1'b1;
          cnt_wval = cnt_sel + CNT_W'(1);
        end
        state_nxt = scoa_pkg::S_RESP;
      end

      scoa_pkg::S_SEARCH: begin
        // Walk up from the requested class to the first non-empty stack
        if (!cls_in_range) begin
          status_nxt = scoa_pkg::ST_OOM;
          state_nxt  = scoa_pkg::S_RESP;
        end else if (cnt_sel != '0) begin
          ram_re    = 1'b1;
          cnt_we    = 1'b1;
          cnt_wval  = cnt_dec;
          state_nxt = scoa_pkg::S_POP;
        end else begin
          cls_nxt = cls_r + scoa_pkg::CLS_W'(1);
        end
      end

      scoa_pkg::S_POP: begin
        offset_nxt = ram_rdata;
        start_nxt  = sum[scoa_pkg::BUMP_W-1:0];
        if (cls_r == k_r) begin
          state_nxt = scoa_pkg::S_RESP;
        end else begin
          cls_nxt   = cls_r - scoa_pkg::CLS_W'(1);
          state_nxt = scoa_pkg::S_SPLIT;
        end
      end

      scoa_pkg::S_SPLIT: begin
        // Push one leftover piece per class, largest first
        if (cnt_full) begin
          status_nxt = scoa_pkg::ST_FULL;
        end else begin
          ram_we   = 1'b1;
          cnt_we   = 1'b1;
          cnt_wval = cnt_sel + CNT_W'(1);
        end
        start_nxt = sum[scoa_pkg::BUMP_W-1:0];
        if (cls_r == k_r) begin
          state_nxt = scoa_pkg::S_RESP;
        end else begin
          cls_nxt = cls_r - scoa_pkg::CLS_W'(1);
        end
      end

      scoa_pkg::S_RESP: begin
        if (res_ready) begin
          state_nxt = scoa_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = scoa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scoa_pkg::S_IDLE;
      bump_r  <= '0;
      for (int i = 0; i < scoa_pkg::NUM_CLASSES; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      bump_r  <= bump_nxt;
      if (cnt_we && cls_in_range) begin
        cnt_r[cls_idx] <= cnt_wval;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_type_r <= req_type_nxt;
    k_r        <= k_nxt;
    cls_r      <= cls_nxt;
    foff_r     <= foff_nxt;
    start_r    <= start_nxt;
    offset_r   <= offset_nxt;
    status_r   <= status_nxt;
  end

endmodule
